// ----- src/crsf_rc_frame_parser_macros.svh -----
// Assertion macros shared by the parser's checker.
`ifndef CRSF_RC_FRAME_PARSER_MACROS_SVH
`define CRSF_RC_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define CRSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define CRSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/crsf_pkg.sv -----
// Shared types, constants and helpers of the CRSF RC frame parser.
package crsf_pkg;

  localparam int BUFFER_BYTES_DEF = 128;
  localparam int MAX_LENGTH_DEF   = 62;

  localparam logic [7:0] CRC_POLY  = 8'hD5;
  localparam logic [7:0] TYPE_RC   = 8'h16;
  localparam logic [7:0] RC_LENGTH = 8'd24;
  localparam logic [7:0] MIN_LEN   = 8'd2;
  localparam int         MIN_BUF   = 4;
  localparam int         CH_BITS   = 11;
  localparam int         PAY_BITS  = 176;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WAIT,
    ST_SCAN,
    ST_LEN,
    ST_CRC,
    ST_CMP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clr;
    logic step;
  } crc_ctl_t;

  function automatic logic known_address(input logic [7:0] a);
    logic k;
    case (a) inside
      8'h00, 8'h10, 8'h80, 8'h8A, 8'hC0, 8'hC2,
      8'hC4, 8'hC8, 8'hCA, 8'hCC, 8'hEA: k = 1'b1;
      default: k = 1'b0;
    endcase
    return k;
  endfunction

endpackage

// ----- src/crsf_rc_mem.sv -----
// Byte buffer memory: one write port, one registered read port.
module crsf_rc_mem #(
  parameter int DEPTH = crsf_pkg::BUFFER_BYTES_DEF,
  parameter int IW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [IW-1:0] raddr,
  output logic [7:0]    rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/crsf_rc_crc.sv -----
// CRC-8 DVB-S2 accumulator, one byte per step.
module crsf_rc_crc (
  input  logic               clk,
  input  crsf_pkg::crc_ctl_t ctl,
  input  logic [7:0]         data,
  output logic [7:0]         crc
);
  import crsf_pkg::*;

  logic [7:0] crc_next;

  always_comb begin
    crc_next = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      crc_next = crc_next[7] ? ((crc_next << 1) ^ CRC_POLY) : (crc_next << 1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      crc <= '0;
    end else if (ctl.step) begin
      crc <= crc_next;
    end
  end
endmodule

// ----- src/crsf_rc_frame_parser.sv -----
// Top level of the CRSF RC channels frame parser.
// Input channel: in_valid/in_ready carry one serial byte (data_byte) with its
// timestamp (time_us). Output channel: out_valid/out_ready carry one RC channel
// per transaction: channel_index 0..15, channel_value, frame_time_us and
// last_channel, set on channel 15.
// Each byte goes into a circular buffer held in a single-port-read memory, then
// a sequencer walks the buffer: hunt for a known address, check the length,
// run the CRC one byte at a time through a shared CRC unit, and consume or
// drop. Every buffer read issues the address in a wait state, then uses the
// registered data, and each pass of the loop goes through a check state. A byte
// that leaves fewer than four buffered returns to idle through the check state,
// bringing in_ready back. A failed candidate drops one byte and the loop
// retries, so a buffer of overlapping bad candidates (up to 128 bytes) can
// have each of its offsets walked in turn within one step.
// in_ready is high only while idle. When a step finds a good channels frame,
// the last one is held and sixteen transactions follow, one per cycle at best;
// a stalled receiver holds the block in that phase, with the payload stable.
// Reset (rst, synchronous) empties the buffer and returns to idle; buffer
// contents are never cleared, only the fill count.
module crsf_rc_frame_parser #(
  parameter int BUFFER_BYTES     = crsf_pkg::BUFFER_BYTES_DEF,
  parameter int MAX_LENGTH_FIELD = crsf_pkg::MAX_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic [31:0] time_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  channel_index,
  output logic [10:0] channel_value,
  output logic [31:0] frame_time_us,
  output logic        last_channel
);
  import crsf_pkg::*;

  localparam int IW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam int SW = CW + 1;

  state_t state, state_next, ret, ret_next;

  logic [IW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] off, off_next;
  logic [7:0]    len, len_next;
  logic [7:0]    ftype;
  logic          have, have_next;
  logic [31:0]   stamp;
  logic [PAY_BITS-1:0] pay_scr, pay_emit;
  logic [3:0]    idx;

  logic          in_fire, out_fire;
  logic          drop_en;
  logic [CW-1:0] drop_n;
  logic [SW-1:0] rd_sum, wr_sum, hd_sum;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [7:0]    mem_q, crc_q;
  logic [8:0]    total;
  logic          len_bad, len_short, last_crc;
  crc_ctl_t      crc_ctl;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign total    = 9'(len) + 9'd2;
  assign len_bad  = (mem_q < MIN_LEN) || (9'(mem_q) > 9'(MAX_LENGTH_FIELD));
  assign len_short = 9'(count) < (9'(mem_q) + 9'd2);
  assign last_crc = (8'(off) == len);

  // Circular addressing: both operands stay below the depth.
  assign rd_sum  = SW'(head) + SW'(off);
  assign rd_addr = (rd_sum >= SW'(BUFFER_BYTES)) ? IW'(rd_sum - SW'(BUFFER_BYTES))
                                                 : IW'(rd_sum);
  assign wr_sum  = SW'(head) + SW'(count);
  assign wr_addr = (count == CW'(BUFFER_BYTES)) ? head :
                   (wr_sum >= SW'(BUFFER_BYTES)) ? IW'(wr_sum - SW'(BUFFER_BYTES))
                                                 : IW'(wr_sum);
  assign hd_sum  = SW'(head) + SW'(drop_n);

  crsf_rc_mem #(.DEPTH(BUFFER_BYTES), .IW(IW)) u_mem (
    .clk   (clk),
    .we    (in_fire),
    .waddr (wr_addr),
    .wdata (data_byte),
    .raddr (rd_addr),
    .rdata (mem_q)
  );

  crsf_rc_crc u_crc (
    .clk  (clk),
    .ctl  (crc_ctl),
    .data (mem_q),
    .crc  (crc_q)
  );

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    ret_next   = ret;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (count < CW'(MIN_BUF)) begin
          state_next = have ? ST_EMIT : ST_IDLE;
        end else begin
          state_next = ST_WAIT;
          ret_next   = ST_SCAN;
        end
      end
      ST_WAIT: state_next = ret;
      ST_SCAN: begin
        if (!known_address(mem_q)) begin
          if (count == CW'(1)) begin
            state_next = have ? ST_EMIT : ST_IDLE;
          end else begin
            state_next = ST_WAIT;
            ret_next   = ST_SCAN;
          end
        end else if (count < CW'(MIN_BUF)) begin
          state_next = have ? ST_EMIT : ST_IDLE;
        end else begin
          state_next = ST_WAIT;
          ret_next   = ST_LEN;
        end
      end
      ST_LEN: begin
        if (len_bad) begin
          state_next = ST_CHECK;
        end else if (len_short) begin
          state_next = have ? ST_EMIT : ST_IDLE;
        end else begin
          state_next = ST_WAIT;
          ret_next   = ST_CRC;
        end
      end
      ST_CRC: begin
        state_next = ST_WAIT;
        ret_next   = last_crc ? ST_CMP : ST_CRC;
      end
      ST_CMP: state_next = ST_CHECK;
      ST_EMIT: begin
        if (out_fire && idx == 4'hF) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath controls and next values.
  always_comb begin
    off_next  = off;
    len_next  = len;
    have_next = have;
    drop_en   = 1'b0;
    drop_n    = CW'(1);
    crc_ctl   = '0;
    unique case (state)
      ST_CHECK: off_next = '0;
      ST_SCAN: begin
        if (!known_address(mem_q)) begin
          drop_en  = 1'b1;
          off_next = '0;
        end else begin
          off_next = IW'(1);
        end
      end
      ST_LEN: begin
        len_next    = mem_q;
        off_next    = IW'(2);
        crc_ctl.clr = 1'b1;
        if (len_bad) drop_en = 1'b1;
      end
      ST_CRC: begin
        crc_ctl.step = 1'b1;
        off_next     = off + IW'(1);
      end
      ST_CMP: begin
        drop_en = 1'b1;
        if (crc_q == mem_q && ftype == TYPE_RC && len == RC_LENGTH) begin
          have_next = 1'b1;
          drop_n    = CW'(total);
        end else if (crc_q == mem_q && ftype != TYPE_RC) begin
          drop_n = CW'(total);
        end
      end
      default: ;
    endcase
    head_next  = head;
    count_next = count;
    if (drop_en) begin
      head_next  = (hd_sum >= SW'(BUFFER_BYTES)) ? IW'(hd_sum - SW'(BUFFER_BYTES))
                                                 : IW'(hd_sum);
      count_next = count - drop_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
      head  <= '0;
      count <= '0;
      have  <= 1'b0;
      idx   <= '0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      if (in_fire) begin
        // A full buffer starts over with this byte.
        count <= (count == CW'(BUFFER_BYTES)) ? CW'(1) : count + CW'(1);
        have  <= 1'b0;
        idx   <= '0;
      end else begin
        head  <= head_next;
        count <= count_next;
        have  <= have_next;
        if (out_fire) begin
          idx <= idx + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    off <= off_next;
    len <= len_next;
    if (in_fire) begin
      stamp <= time_us;
    end
    if (state == ST_CRC) begin
      // Keep the last 22 bytes walked: the payload once the walk ends.
      pay_scr <= {mem_q, pay_scr[PAY_BITS-1:8]};
      if (off == IW'(2)) ftype <= mem_q;
    end
    if (state == ST_CMP && have_next && !have) begin
      pay_emit <= pay_scr;
    end else if (state == ST_CMP && crc_q == mem_q && ftype == TYPE_RC &&
                 len == RC_LENGTH) begin
      pay_emit <= pay_scr;
    end else if (out_fire) begin
      pay_emit <= pay_emit >> CH_BITS;
    end
  end

  assign in_ready      = (state == ST_IDLE);
  assign out_valid     = (state == ST_EMIT);
  assign channel_index = idx;
  assign channel_value = pay_emit[CH_BITS-1:0];
  assign frame_time_us = stamp;
  assign last_channel  = (idx == 4'hF);
endmodule

// ----- src/crsf_rc_checker.sv -----
// Port checker for the CRSF RC frame parser, bound to the top level.
`include "crsf_rc_frame_parser_macros.svh"

module crsf_rc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  channel_index,
  input logic [10:0] channel_value,
  input logic [31:0] frame_time_us,
  input logic        last_channel
);
  `CRSF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(channel_index) && $stable(channel_value) && $stable(frame_time_us), "output changed while stalled")
  `CRSF_ASSERT_NOW(a_busy_emit, out_valid, !in_ready, "input taken while emitting")
  `CRSF_ASSERT_NEXT(a_take_busy, in_valid && in_ready, !in_ready, "ready held after input transaction")
  `CRSF_ASSERT_NEXT(a_index_step, out_valid && out_ready && !last_channel, out_valid && channel_index == $past(channel_index) + 4'd1, "channel run broken")
  `CRSF_ASSERT_NOW(a_last_index, out_valid && last_channel, channel_index == 4'hF, "last flag off channel 15")
endmodule

bind crsf_rc_frame_parser crsf_rc_checker u_chk (.*);
